>>> hw/rtl/mspt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspt_pkg
// Shared types and constants of the multi-slot pulse timer.
// ----------------------------------------------------------------------------
package mspt_pkg;

	localparam int PIN_W  = 6;
	localparam int TIME_W = 32;

	typedef logic [PIN_W-1:0]  pin_t;
	typedef logic [TIME_W-1:0] time_t;

	// command kind (s_tuser)
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// result action (m_tuser)
	localparam logic ACT_DRIVE  = 1'b0;
	localparam logic ACT_TOGGLE = 1'b1;

	// request from the input stage to the slot table
	typedef struct packed {
		logic  start;
		logic  tick;
		pin_t  pin;
		time_t dur;
	} req_t;

	// expiry result offered by the slot table
	typedef struct packed {
		logic valid;
		pin_t pin;
		logic last;
	} emit_t;

endpackage

>>> hw/rtl/mspt_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspt_slot_table
// Millisecond counter, slot storage, allocation, expiry compare and the
// queue of expired slots still to be reported.
// ----------------------------------------------------------------------------
module mspt_slot_table #(
	parameter int NUM_SLOTS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mspt_pkg::req_t  req,
	input  logic            emit_take,
	output logic            sched,
	output logic            pend_empty,
	output mspt_pkg::emit_t emit
);

	logic [NUM_SLOTS-1:0]  busy_q;
	logic [NUM_SLOTS-1:0]  pend_q;
	mspt_pkg::time_t       time_q;
	mspt_pkg::pin_t        pin_q [NUM_SLOTS];
	mspt_pkg::time_t       end_q [NUM_SLOTS];

	logic [NUM_SLOTS-1:0]  alloc_oh;
	logic [NUM_SLOTS-1:0]  exp_mask;
	logic [NUM_SLOTS-1:0]  emit_oh;
	mspt_pkg::time_t       time_nxt;
	mspt_pkg::time_t       end_new;
	mspt_pkg::pin_t        emit_pin;

	assign time_nxt = time_q + mspt_pkg::time_t'(1);
	assign end_new  = time_q + req.dur;

	// lowest free slot and lowest pending slot, one-hot
	always_comb begin
		logic found_a;
		logic found_e;
		found_a  = 1'b0;
		found_e  = 1'b0;
		alloc_oh = '0;
		emit_oh  = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!busy_q[i] && !found_a) begin
				alloc_oh[i] = 1'b1;
				found_a     = 1'b1;
			end
			if (pend_q[i] && !found_e) begin
				emit_oh[i] = 1'b1;
				found_e    = 1'b1;
			end
		end
	end

	always_comb begin
		emit_pin = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			exp_mask[i] = busy_q[i] && (end_q[i] <= time_nxt);
			if (emit_oh[i]) begin
				emit_pin = emit_pin | pin_q[i];
			end
		end
	end

	assign sched      = |alloc_oh;
	assign pend_empty = (pend_q == '0);
	assign emit.valid = !pend_empty;
	assign emit.pin   = emit_pin;
	assign emit.last  = ((pend_q & ~emit_oh) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			busy_q <= '0;
			pend_q <= '0;
		end else begin
			if (req.tick) begin
				time_q <= time_nxt;
				busy_q <= busy_q & ~exp_mask;
				pend_q <= exp_mask;
			end else begin
				if (req.start) begin
					busy_q <= busy_q | alloc_oh;
				end
				if (emit_take) begin
					pend_q <= pend_q & ~emit_oh;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (req.start && alloc_oh[i]) begin
				pin_q[i] <= req.pin;
				end_q[i] <= end_new;
			end
		end
	end

endmodule

>>> hw/rtl/multi_slot_pulse_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_pulse_timer
// Table of one-shot pulse slots on a free-running millisecond counter.
// ----------------------------------------------------------------------------
// A start item yields one drive result and can be taken every cycle while the
// output is not stalled and no expired slots are pending; its result is
// registered in the input stage and then in the output register. A tick item
// advances time and frees every slot whose end time has been reached; the
// expired slots are then reported as toggle items in slot order, one per cycle
// from the output register while the output is not stalled, and the next input
// item is processed after the last of them. When all slots are busy a start
// still drives its pin with was_scheduled 0.
// ----------------------------------------------------------------------------
module multi_slot_pulse_timer #(
	parameter int NUM_SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // pin_id[5:0], duration[37:6], end_level[38]
	input  logic [0:0]  s_tuser,   // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_pin[5:0], drive_level[6], was_scheduled[7]
	output logic [0:0]  m_tuser,   // action[0]
	output logic        m_tlast    // last_result
);

	logic                   valid_s1;
	logic                   cmd_s1;
	mspt_pkg::pin_t         pin_s1;
	mspt_pkg::time_t        dur_s1;
	logic                   endl_s1;

	logic                   out_free;
	logic                   proc;
	logic                   emit_take;
	logic                   sched;
	logic                   pend_empty;
	mspt_pkg::req_t         req;
	mspt_pkg::emit_t        emit;

	logic                   m_tvalid_q;
	logic [7:0]             m_tdata_q;
	logic                   m_tuser_q;
	logic                   m_tlast_q;

	assign out_free  = !m_tvalid_q || m_tready;
	assign proc      = valid_s1 && pend_empty && (cmd_s1 == mspt_pkg::CMD_TICK || out_free);
	assign emit_take = emit.valid && out_free;
	assign s_tready  = !valid_s1 || proc;

	assign req.start = proc && (cmd_s1 == mspt_pkg::CMD_START);
	assign req.tick  = proc && (cmd_s1 == mspt_pkg::CMD_TICK);
	assign req.pin   = pin_s1;
	assign req.dur   = dur_s1;

	mspt_slot_table #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.emit_take (emit_take),
		.sched     (sched),
		.pend_empty(pend_empty),
		.emit      (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser[0];
			pin_s1  <= s_tdata[5:0];
			dur_s1  <= s_tdata[37:6];
			endl_s1 <= s_tdata[38];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (req.start || emit_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			m_tdata_q <= {sched, ~endl_s1, pin_s1};
			m_tuser_q <= mspt_pkg::ACT_DRIVE;
			m_tlast_q <= 1'b1;
		end else if (emit_take) begin
			m_tdata_q <= {1'b1, 1'b0, emit.pin};
			m_tuser_q <= mspt_pkg::ACT_TOGGLE;
			m_tlast_q <= emit.last;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;
	assign m_tlast    = m_tlast_q;

endmodule

>>> tb/multi_slot_pulse_timer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_pulse_timer_tb
// Self-checking bench for the one-shot pulse slot table.
// ----------------------------------------------------------------------------
// A queue of start and tick commands feeds a clocked driver. A clocked monitor
// keeps a shadow slot table, predicts the drive and toggle items of every
// accepted command, and checks each output item in order. Directed commands
// cover the corner cases. Random commands follow, with idle bursts on both
// sides, a long output stall and drain pauses.
// ----------------------------------------------------------------------------
module multi_slot_pulse_timer_tb;

	localparam int NUM_SLOTS  = 4;
	localparam int RAND_ITEMS = 360;
	localparam int WDOG_LIMIT = 4000;
	localparam int TAIL_ITEMS = 50;
	localparam int HOLD_AFTER = 150;
	localparam int HOLD_LEN   = 300;

	typedef struct {
		logic            kind;
		mspt_pkg::pin_t  pin;
		mspt_pkg::time_t dur;
		logic            end_level;
		bit              hold_drain;
	} pulse_cmd_t;

	typedef struct {
		logic           action;
		mspt_pkg::pin_t pin;
		logic           level;
		logic           sched;
		logic           last;
	} pin_action_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // pin_id[5:0], duration[37:6], end_level[38]
	logic [0:0]  s_tuser = '0;   // cmd[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // out_pin[5:0], drive_level[6], was_scheduled[7]
	logic [0:0]  m_tuser;        // action[0]
	logic        m_tlast;

	pulse_cmd_t  cmd_q[$];
	pin_action_t action_q[$];

	// shadow slot table
	mspt_pkg::time_t clock_ms = '0;
	bit              slot_busy_m [NUM_SLOTS];
	mspt_pkg::pin_t  slot_pin_m  [NUM_SLOTS];
	mspt_pkg::time_t slot_end_m  [NUM_SLOTS];

	int  gen_ms = 0;
	int  errors = 0;
	int  n_start = 0, n_tick = 0, n_toggle = 0, n_full = 0, max_burst = 0;
	int  exp_cnt = 0;
	bit  tail_phase = 1'b0;
	bit  rx_hold = 1'b0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  hold_cnt = 0;
	bit  hold_done = 1'b0;
	int  taken = 0;
	int  quiet_cycles = 0;

	multi_slot_pulse_timer #(.NUM_SLOTS(NUM_SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic queue_cmd(input logic kind, input mspt_pkg::pin_t pin,
			input mspt_pkg::time_t dur, input logic lvl, input bit hold);
		pulse_cmd_t c;
		c.kind = kind;
		c.pin = pin;
		c.dur = dur;
		c.end_level = lvl;
		c.hold_drain = hold;
		cmd_q.push_back(c);
		if (kind == mspt_pkg::CMD_TICK)
			gen_ms++;
	endtask

	task automatic predict_pulses(input logic kind, input mspt_pkg::pin_t pin,
			input mspt_pkg::time_t dur, input logic lvl);
		pin_action_t a;
		bit expiring [NUM_SLOTS];
		bit placed;
		int n;
		int k;
		placed = 1'b0;
		n = 0;
		k = 0;
		if (kind == mspt_pkg::CMD_START) begin
			n_start++;
			for (int i = 0; i < NUM_SLOTS; i++)
				if (!placed && !slot_busy_m[i]) begin
					slot_busy_m[i] = 1'b1;
					slot_pin_m[i] = pin;
					slot_end_m[i] = clock_ms + dur;
					placed = 1'b1;
				end
			if (!placed)
				n_full++;
			a.action = mspt_pkg::ACT_DRIVE;
			a.pin = pin;
			a.level = ~lvl;
			a.sched = placed;
			a.last = 1'b1;
			action_q.push_back(a);
		end else begin
			n_tick++;
			clock_ms = clock_ms + 1;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				expiring[i] = slot_busy_m[i] && (slot_end_m[i] <= clock_ms);
				if (expiring[i])
					n++;
			end
			for (int i = 0; i < NUM_SLOTS; i++)
				if (expiring[i]) begin
					k++;
					slot_busy_m[i] = 1'b0;
					a.action = mspt_pkg::ACT_TOGGLE;
					a.pin = slot_pin_m[i];
					a.level = 1'b0;
					a.sched = 1'b1;
					a.last = (k == n);
					action_q.push_back(a);
				end
			n_toggle += n;
			if (n > max_burst)
				max_burst = n;
		end
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errors++;
			if (errors <= 40)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, name, exp_v, act_v);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : driver
		pulse_cmd_t c;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			tx_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (cmd_q.size() < TAIL_ITEMS)
				tail_phase <= 1'b1;
			if (tx_gap != 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (cmd_q.size() != 0 &&
					!(cmd_q[0].hold_drain && (exp_cnt != 0 || s_tvalid))) begin
				c = cmd_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {1'b0, c.end_level, c.dur, c.pin};
				s_tuser <= c.kind;
				if (!tail_phase && !rx_hold && $urandom_range(0, 9) == 0)
					tx_gap = $urandom_range(1, 18);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold <= 1'b0;
			rx_gap = 0;
			hold_cnt = 0;
			hold_done = 1'b0;
			taken = 0;
		end else begin
			if (m_tvalid && m_tready)
				taken++;
			if (hold_cnt != 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
				if (hold_cnt == 0)
					rx_hold <= 1'b0;
			end else if (!hold_done && taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_cnt = HOLD_LEN;
				rx_hold <= 1'b1;
				m_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!tail_phase && $urandom_range(0, 7) == 0)
					rx_gap = $urandom_range(1, 18);
			end
		end
	end

	// monitor: predict on accepted commands, check accepted output items
	always @(posedge clk) begin : monitor
		pin_action_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_pulses(s_tuser[0], s_tdata[5:0], s_tdata[37:6], s_tdata[38]);
			if (m_tvalid && m_tready) begin
				if (action_q.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected item, expected none, actual pin %0d action %0d",
						$time, m_tdata[5:0], m_tuser[0]);
				end else begin
					e = action_q.pop_front();
					check_field("action", e.action, m_tuser[0]);
					check_field("out_pin", e.pin, m_tdata[5:0]);
					check_field("drive_level", e.level, m_tdata[6]);
					check_field("was_scheduled", e.sched, m_tdata[7]);
					check_field("last_result", e.last, m_tlast);
				end
			end
			exp_cnt <= action_q.size();
		end
	end

	// watchdog
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("%0t ns: no progress for %0d cycles", $time, WDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int r;
		// zero duration expiring on the first tick, then a quiet tick
		queue_cmd(mspt_pkg::CMD_START, 6'd0, 32'd0, 1'b0, 1'b0);
		queue_cmd(mspt_pkg::CMD_TICK, 6'd0, 32'd0, 1'b0, 1'b0);
		queue_cmd(mspt_pkg::CMD_TICK, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0);
		// max duration wraps below current time
		queue_cmd(mspt_pkg::CMD_START, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0);
		// same pin again, then fill the table
		queue_cmd(mspt_pkg::CMD_START, 6'd63, 32'd1, 1'b0, 1'b0);
		queue_cmd(mspt_pkg::CMD_START, 6'd21, 32'd3, 1'b1, 1'b0);
		queue_cmd(mspt_pkg::CMD_START, 6'd42, 32'd2, 1'b0, 1'b0);
		// table full
		queue_cmd(mspt_pkg::CMD_START, 6'd7, 32'd5, 1'b1, 1'b0);
		queue_cmd(mspt_pkg::CMD_TICK, 6'd0, 32'd0, 1'b0, 1'b0);
		queue_cmd(mspt_pkg::CMD_TICK, 6'd0, 32'd0, 1'b0, 1'b0);
		queue_cmd(mspt_pkg::CMD_TICK, 6'd0, 32'd0, 1'b0, 1'b0);
		// four slots expiring on one tick
		queue_cmd(mspt_pkg::CMD_START, 6'd1, 32'd1, 1'b1, 1'b0);
		queue_cmd(mspt_pkg::CMD_START, 6'd2, 32'd1, 1'b0, 1'b0);
		queue_cmd(mspt_pkg::CMD_START, 6'd3, 32'hFFFF_FFFF, 1'b1, 1'b0);
		queue_cmd(mspt_pkg::CMD_START, 6'd4, 32'd0, 1'b0, 1'b0);
		queue_cmd(mspt_pkg::CMD_TICK, 6'd0, 32'd0, 1'b0, 1'b0);
		// end time wraps exactly to zero
		queue_cmd(mspt_pkg::CMD_START, 6'd33, 32'd0 - 32'(gen_ms), 1'b1, 1'b1);
		queue_cmd(mspt_pkg::CMD_TICK, 6'd0, 32'd0, 1'b0, 1'b0);

		for (int k = 0; k < RAND_ITEMS; k++) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				for (int j = 0; j < $urandom_range(3, 5); j++)
					queue_cmd(mspt_pkg::CMD_START, mspt_pkg::pin_t'($urandom_range(0, 63)),
						mspt_pkg::time_t'($urandom_range(0, 6)),
						1'($urandom_range(0, 1)), 1'b0);
			end else if (r < 58) begin
				queue_cmd(mspt_pkg::CMD_TICK, mspt_pkg::pin_t'($urandom_range(0, 63)),
					mspt_pkg::time_t'($urandom), 1'($urandom_range(0, 1)),
					k % 100 == 99);
			end else if (r < 86 || gen_ms == 0) begin
				queue_cmd(mspt_pkg::CMD_START, mspt_pkg::pin_t'($urandom_range(0, 63)),
					mspt_pkg::time_t'($urandom_range(0, 6)), 1'($urandom_range(0, 1)),
					k % 100 == 99);
			end else begin
				queue_cmd(mspt_pkg::CMD_START, mspt_pkg::pin_t'($urandom_range(0, 63)),
					32'd0 - 32'($urandom_range(1, gen_ms)), 1'($urandom_range(0, 1)),
					k % 100 == 99);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (action_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (action_q.size() != 0) begin
			errors++;
			$display("%0t ns: %0d expected items left over", $time, action_q.size());
		end

		$display("Ran %0d starts (%0d with a full table) and %0d ticks at %0d ms.",
			n_start, n_full, n_tick, clock_ms);
		$display("Checked %0d toggles, up to %0d on one tick; %0d mismatches.",
			n_toggle, max_burst, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> multi_slot_pulse_timer.f
hw/rtl/mspt_pkg.sv
hw/rtl/mspt_slot_table.sv
hw/rtl/multi_slot_pulse_timer.sv
tb/multi_slot_pulse_timer_tb.sv
